FILE: sv/twtc_pkg.sv
package twtc_pkg;
  localparam int CoordW = 16;
  localparam int TimeW = 24;
  localparam int SqW = 33;
  localparam int RootW = 17;
  localparam int RootSteps = 17;
  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  typedef enum logic [2:0] {
    REG_DEPOT_X = 3'd0,
    REG_DEPOT_Y = 3'd1,
    REG_DEPOT_OPEN = 3'd2,
    REG_DEPOT_SERVICE = 3'd3,
    REG_HORIZON = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    FAIL_NONE = 2'd0,
    FAIL_WINDOW = 2'd1,
    FAIL_HORIZON = 2'd2
  } fail_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } sqrt_ctl_t;
endpackage

FILE: sv/twtc_sqrt.sv
module twtc_sqrt
  import twtc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SqW-1:0]    radicand,
  output logic [RootW-1:0]  root,
  output sqrt_ctl_t         ctl
);
  logic [SqW+1:0] rem;
  logic [SqW:0] src;
  logic [RootW-1:0] res;
  logic [4:0] cnt;
  logic busy;
  logic done;
  logic [RootW+1:0] trial;
  logic [SqW+1:0] rem_sh;

  assign rem_sh = {rem[SqW-1:0], src[SqW -: 2]};
  assign trial = {res, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 5'(RootSteps);
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      src <= {1'b0, radicand};
      rem <= '0;
      res <= '0;
    end else if (busy) begin
      src <= {src[SqW-2:0], 2'b00};
      if (rem_sh >= (SqW+2)'(trial)) begin
        rem <= rem_sh - (SqW+2)'(trial);
        res <= {res[RootW-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        res <= {res[RootW-2:0], 1'b0};
      end
    end
  end

  assign root = res;
  assign ctl = '{start: start, busy: busy, done: done};
endmodule

FILE: sv/time_window_tour_checker_top.sv
// An accepted transaction computes two roots in turn (leg to the stop, then leg back to the depot),
// then evaluates; the next transaction is taken only once the result has been taken.
// The shared square-root unit (one root bit per cycle, 17 bits) computes both roots.
// Output is held in a register until taken; input is stalled while busy or a result waits.
// Synchronous active-high reset: depot at origin, horizon at maximum, tour cleared.
module time_window_tour_checker_top
  import twtc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [TimeW-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               func,
  input  logic [CoordW-1:0]  node_x,
  input  logic [CoordW-1:0]  node_y,
  input  logic [TimeW-1:0]   stop_service,
  input  logic [TimeW-1:0]   window_open,
  input  logic [TimeW-1:0]   window_close,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [TimeW-1:0]   finish_time,
  output logic               tour_done
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SQ1  = 6'b000010,
    S_RT1  = 6'b000100,
    S_SQ2  = 6'b001000,
    S_RT2  = 6'b010000,
    S_EVAL = 6'b100000
  } state_t;

  state_t state, state_next;
  logic [CoordW-1:0] depot_x, depot_y, last_x, last_y, nx, ny;
  logic [TimeW-1:0] depot_open, depot_service, horizon, elapsed;
  logic [TimeW-1:0] svc, wopen, wclose;
  logic [1:0] fail_code;
  logic closing;
  logic [RootW-1:0] d1;
  logic [SqW-1:0] sq;
  logic [CoordW-1:0] ax, ay, bx, by, dx, dy;
  logic sq_start;
  logic sq_go;
  logic [RootW-1:0] root;
  sqrt_ctl_t sctl;
  logic [TimeW+1:0] arr, start_t, fin, tot;
  logic accept;
  logic [1:0] fail_next;
  logic [TimeW-1:0] elapsed_next;
  logic stop_ok;

  assign in_stall = (state != S_IDLE) || out_valid;
  assign accept = in_valid && !in_stall;

  always_comb begin
    if (state == S_SQ1) begin
      ax = last_x; ay = last_y; bx = nx; by = ny;
    end else begin
      ax = nx; ay = ny; bx = depot_x; by = depot_y;
    end
    dx = (ax >= bx) ? ax - bx : bx - ax;
    dy = (ay >= by) ? ay - by : by - ay;
  end

  always_ff @(posedge clk) begin
    sq <= SqW'(dx * dx) + SqW'(dy * dy);
  end

  // sq holds the leg in the cycle after each SQ state: start the root then
  assign sq_start = sq_go;

  twtc_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(sq), .root(root), .ctl(sctl)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_SQ1;
      S_SQ1:  state_next = S_RT1;
      S_RT1:  if (sctl.done) state_next = S_SQ2;
      S_SQ2:  state_next = S_RT2;
      S_RT2:  if (sctl.done) state_next = S_EVAL;
      S_EVAL: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    arr = (TimeW+2)'(elapsed) + (TimeW+2)'(d1);
    start_t = (arr > (TimeW+2)'(wopen)) ? arr : (TimeW+2)'(wopen);
    fin = start_t + (TimeW+2)'(svc);
    tot = fin + (TimeW+2)'(root);
  end

  always_comb begin
    fail_next = fail_code;
    elapsed_next = elapsed;
    stop_ok = 1'b0;
    if (fail_code == FAIL_NONE) begin
      if (tot > (TimeW+2)'(horizon)) begin
        fail_next = FAIL_HORIZON;
      end else if (arr > (TimeW+2)'(wclose)) begin
        fail_next = FAIL_WINDOW;
      end else begin
        elapsed_next = (fin > (TimeW+2)'(TimeMax)) ? TimeMax : fin[TimeW-1:0];
        stop_ok = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      sq_go <= 1'b0;
      depot_x <= '0;
      depot_y <= '0;
      depot_open <= '0;
      depot_service <= '0;
      horizon <= TimeMax;
      elapsed <= '0;
      last_x <= '0;
      last_y <= '0;
      fail_code <= FAIL_NONE;
    end else begin
      state <= state_next;
      sq_go <= (state == S_SQ1) || (state == S_SQ2);
      if (state == S_EVAL) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DEPOT_X: begin
            depot_x <= cfg_data[CoordW-1:0];
            last_x <= cfg_data[CoordW-1:0];
          end
          REG_DEPOT_Y: begin
            depot_y <= cfg_data[CoordW-1:0];
            last_y <= cfg_data[CoordW-1:0];
          end
          REG_DEPOT_OPEN: depot_open <= cfg_data;
          REG_DEPOT_SERVICE: depot_service <= cfg_data;
          REG_HORIZON: horizon <= cfg_data;
          default: ;
        endcase
      end
      if (state == S_EVAL) begin
        status <= fail_next;
        finish_time <= elapsed_next;
        tour_done <= closing;
        if (closing) begin
          elapsed <= '0;
          last_x <= depot_x;
          last_y <= depot_y;
          fail_code <= FAIL_NONE;
        end else begin
          fail_code <= fail_next;
          elapsed <= elapsed_next;
          if (stop_ok) begin
            last_x <= nx;
            last_y <= ny;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      closing <= func;
      nx <= func ? depot_x : node_x;
      ny <= func ? depot_y : node_y;
      svc <= func ? depot_service : stop_service;
      wopen <= func ? depot_open : window_open;
      wclose <= func ? horizon : window_close;
    end
    if (state == S_RT1 && sctl.done) d1 <= root;
  end

  assert property (@(posedge clk) disable iff (rst) sctl.done |-> !sctl.busy)
    else $error("root done while busy");
  assert property (@(posedge clk) disable iff (rst) (state == S_EVAL) |=> out_valid)
    else $error("result not presented");
  assert property (@(posedge clk) disable iff (rst) out_valid |-> (state == S_IDLE))
    else $error("work while result pending");
endmodule

FILE: dv/tb_top.sv
module tb_top
  import twtc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic              func;
    logic [CoordW-1:0] nx;
    logic [CoordW-1:0] ny;
    logic [TimeW-1:0]  svc;
    logic [TimeW-1:0]  wopen;
    logic [TimeW-1:0]  wclose;
  } stop_t;

  typedef struct {
    logic [1:0]       status;
    logic [TimeW-1:0] fin;
    logic             done;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [TimeW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic func = 1'b0;
  logic [CoordW-1:0] node_x = '0, node_y = '0;
  logic [TimeW-1:0] stop_service = '0, window_open = '0, window_close = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic [TimeW-1:0] finish_time;
  logic tour_done;

  time_window_tour_checker_top dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  stop_t    pending_stops[$];
  verdict_t expected_verdicts[$];
  int  send_idle_pct = 0, recv_idle_pct = 0;
  int  hold_cycles = 0;
  bit  long_hold = 1'b0;
  bit  hold_used = 1'b0;
  bit  accepted = 1'b0;
  bit  failed = 1'b0;

  logic [CoordW-1:0] m_depot_x, m_depot_y, m_last_x, m_last_y;
  logic [TimeW-1:0]  m_depot_open, m_depot_svc, m_horizon, m_elapsed;
  fail_t             m_fail;

  function automatic logic [RootW-1:0] int_root(logic [SqW-1:0] v);
    logic [SqW+1:0] rem, res, bitv;
    rem = (SqW+2)'(v);
    res = '0;
    bitv = 35'd1 << 34;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != '0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[RootW-1:0];
  endfunction

  function automatic logic [RootW-1:0] leg_length(logic [CoordW-1:0] ax, ay, bx, by);
    logic [CoordW-1:0] dx, dy;
    dx = ax >= bx ? ax - bx : bx - ax;
    dy = ay >= by ? ay - by : by - ay;
    return int_root({1'b0, 32'(dx) * 32'(dx)} + {1'b0, 32'(dy) * 32'(dy)});
  endfunction

  task automatic model_reset();
    m_depot_x = '0; m_depot_y = '0; m_depot_open = '0; m_depot_svc = '0;
    m_horizon = TimeMax; m_elapsed = '0; m_last_x = '0; m_last_y = '0;
    m_fail = FAIL_NONE;
  endtask

  function automatic verdict_t predict_verdict(stop_t s);
    logic [CoordW-1:0] nx, ny;
    logic [TimeW-1:0] sv, wo, wc;
    logic [27:0] arr, st, fn;
    verdict_t v;
    nx = s.func ? m_depot_x : s.nx;
    ny = s.func ? m_depot_y : s.ny;
    sv = s.func ? m_depot_svc : s.svc;
    wo = s.func ? m_depot_open : s.wopen;
    wc = s.func ? m_horizon : s.wclose;
    if (m_fail == FAIL_NONE) begin
      arr = 28'(m_elapsed) + 28'(leg_length(m_last_x, m_last_y, nx, ny));
      st = arr > 28'(wo) ? arr : 28'(wo);
      fn = st + 28'(sv);
      if (fn + 28'(leg_length(nx, ny, m_depot_x, m_depot_y)) > 28'(m_horizon)) begin
        m_fail = FAIL_HORIZON;
      end else if (arr > 28'(wc)) begin
        m_fail = FAIL_WINDOW;
      end else begin
        m_elapsed = fn > 28'(TimeMax) ? TimeMax : fn[TimeW-1:0];
        m_last_x = nx;
        m_last_y = ny;
      end
    end
    v.status = m_fail;
    v.fin = m_elapsed;
    v.done = s.func;
    if (s.func) begin
      m_elapsed = '0; m_last_x = m_depot_x; m_last_y = m_depot_y; m_fail = FAIL_NONE;
    end
    return v;
  endfunction

  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || accepted) begin
        if (pending_stops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          func <= pending_stops[0].func;
          node_x <= pending_stops[0].nx;
          node_y <= pending_stops[0].ny;
          stop_service <= pending_stops[0].svc;
          window_open <= pending_stops[0].wopen;
          window_close <= pending_stops[0].wclose;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (long_hold && !hold_used) begin
        hold_cycles = 300;
        hold_used = 1'b1;
      end
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles = hold_cycles - 1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    verdict_t e;
    if (!rst) begin
      accepted = in_valid && !in_stall;
      if (accepted) begin
        expected_verdicts.insert(expected_verdicts.size(), predict_verdict(pending_stops[0]));
        void'(pending_stops.pop_front());
      end
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t: unexpected result status=%0d finish=%0h done=%0d",
                   $time, status, finish_time, tour_done);
          failed = 1'b1;
        end else begin
          e = expected_verdicts.pop_front();
          if (status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, status);
            failed = 1'b1;
          end
          if (finish_time !== e.fin) begin
            $display("%0t: finish_time expected %0h actual %0h", $time, e.fin, finish_time);
            failed = 1'b1;
          end
          if (tour_done !== e.done) begin
            $display("%0t: tour_done expected %0d actual %0d", $time, e.done, tour_done);
            failed = 1'b1;
          end
        end
      end
    end
  end

  function automatic stop_t make_stop(int unsigned f, x, y, sv, wo, wc);
    stop_t s;
    s.func = f[0];
    s.nx = x[CoordW-1:0];
    s.ny = y[CoordW-1:0];
    s.svc = sv[TimeW-1:0];
    s.wopen = wo[TimeW-1:0];
    s.wclose = wc[TimeW-1:0];
    return s;
  endfunction

  function automatic stop_t rand_stop();
    int k;
    k = $urandom_range(9);
    if (k == 0) return make_stop(1, $urandom, $urandom, $urandom, $urandom, $urandom);
    if (k == 1) return make_stop(0, $urandom, $urandom, $urandom, $urandom, $urandom);
    return make_stop(0, $urandom_range(4095), $urandom_range(4095),
                     $urandom_range(2000), $urandom_range(20000),
                     $urandom_range(5000, 60000));
  endfunction

  task automatic add_stop(stop_t s);
    pending_stops.insert(pending_stops.size(), s);
  endtask

  task automatic drain();
    while (pending_stops.size() > 0 || expected_verdicts.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[TimeW-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DEPOT_X: begin m_depot_x = val[CoordW-1:0]; m_last_x = m_depot_x; end
      REG_DEPOT_Y: begin m_depot_y = val[CoordW-1:0]; m_last_y = m_depot_y; end
      REG_DEPOT_OPEN: m_depot_open = val[TimeW-1:0];
      REG_DEPOT_SERVICE: m_depot_svc = val[TimeW-1:0];
      REG_HORIZON: m_horizon = val[TimeW-1:0];
      default: ;
    endcase
  endtask

  task automatic random_phase(int n);
    repeat (n) add_stop(rand_stop());
    drain();
  endtask

  initial begin
    model_reset();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    add_stop(make_stop(0, 'h0010, 'h0000, 0, 0, 100));
    add_stop(make_stop(0, 'hFFFF, 'hFFFF, 'hFFFFFF, 0, 'hFFFFFF));
    add_stop(make_stop(0, 0, 0, 0, 0, 0));
    add_stop(make_stop(1, 0, 0, 0, 0, 0));
    add_stop(make_stop(0, 'h0300, 'h0400, 5, 0, 'hFFFFFF));
    add_stop(make_stop(0, 'h0300, 'h0400, 5, 'h000800, 'hFFFFFF));
    add_stop(make_stop(0, 'h1000, 'h1000, 5, 0, 1));
    add_stop(make_stop(0, 'h0001, 'h0001, 5, 0, 'hFFFFFF));
    add_stop(make_stop(1, 'hFFFF, 'hFFFF, 'hFFFFFF, 'hFFFFFF, 0));
    add_stop(make_stop(0, 'hFFFF, 0, 0, 0, 'hFFFFFF));
    add_stop(make_stop(0, 0, 'hFFFF, 0, 0, 'hFFFFFF));
    add_stop(make_stop(1, 0, 0, 0, 0, 0));
    drain();
    write_reg(REG_HORIZON, 'h000400);
    add_stop(make_stop(0, 'h0100, 'h0100, 'h300, 0, 'hFFFFFF));
    add_stop(make_stop(1, 0, 0, 0, 0, 0));
    drain();
    write_reg(REG_DEPOT_X, 'hFFFF);
    write_reg(REG_DEPOT_Y, 'hFFFF);
    write_reg(REG_DEPOT_OPEN, 'hFFFFFF);
    write_reg(REG_DEPOT_SERVICE, 'hFFFFFF);
    write_reg(REG_HORIZON, 'hFFFFFF);
    add_stop(make_stop(0, 'hFFF0, 'hFFF0, 0, 0, 'hFFFFFF));
    add_stop(make_stop(1, 0, 0, 0, 0, 0));
    drain();

    write_reg(REG_DEPOT_X, 'h0800);
    write_reg(REG_DEPOT_Y, 'h0800);
    write_reg(REG_DEPOT_OPEN, 'h000100);
    write_reg(REG_DEPOT_SERVICE, 'h000020);
    write_reg(REG_HORIZON, 'h020000);
    send_idle_pct = 11; recv_idle_pct = 49;
    random_phase(130);

    write_reg(REG_DEPOT_X, $urandom);
    write_reg(REG_DEPOT_Y, $urandom);
    write_reg(REG_DEPOT_OPEN, $urandom_range(4000));
    write_reg(REG_DEPOT_SERVICE, $urandom);
    write_reg(REG_HORIZON, $urandom_range('hFFFFFF, 'h010000));
    send_idle_pct = 49; recv_idle_pct = 11;
    random_phase(130);

    write_reg(REG_DEPOT_X, 0);
    write_reg(REG_DEPOT_Y, 0);
    write_reg(REG_DEPOT_OPEN, 0);
    write_reg(REG_DEPOT_SERVICE, 0);
    write_reg(REG_HORIZON, 'h00C000);
    send_idle_pct = 0; recv_idle_pct = 0;
    @(negedge clk);
    long_hold = 1'b1;
    random_phase(130);

    if (!failed) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end
endmodule

FILE: time_window_tour_checker_top.f
sv/twtc_pkg.sv
sv/twtc_sqrt.sv
sv/time_window_tour_checker_top.sv
dv/tb_top.sv
